// ----- hw/rtl/dnsar_pkg.sv -----
// ---------------------------------------------------------------------------
// dnsar_pkg
// Shared types and constants of the DNS A-record reply parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dnsar_pkg;

    // parameter default
    localparam int MAX_RECORDS_DEF = 8;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // register map
    localparam logic REG_EXPECTED_ID = 1'b0;
    localparam logic REG_MAX_RECORDS = 1'b1;
    localparam logic [3:0] MAX_RECORDS_RST = 4'd8;

    // result word codes
    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    localparam logic [1:0] VERDICT_NONE  = 2'd0;
    localparam logic [1:0] VERDICT_EMPTY = 2'd1;

    // protocol constants
    localparam logic [3:0] HEADER_LAST   = 4'd11;
    localparam logic [3:0] QFIXED_LEN    = 4'd4;
    localparam logic [3:0] AFIXED_LEN    = 4'd10;
    localparam logic [3:0] AFIXED_RDLEN  = 4'd8;
    localparam logic [7:0] MAX_LABELS    = 8'd128;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] A_RDATA_LEN  = 16'd4;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [1:0]  status;
        logic [3:0]  record_count;
        logic        end_of_run;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dns_a_record_reply_parser_top.sv -----
// ---------------------------------------------------------------------------
// dns_a_record_reply_parser_top
// Byte-wide DNS reply parser that checks the header, skips questions and
// emits A-record addresses followed by a per-message status word.
// ---------------------------------------------------------------------------
// One reply byte is taken per clock while in_stall is low. The parse state is
// updated in the cycle a byte is accepted, and the words it causes (an address,
// a status, or both) go into a 4-entry output queue that drains one word per
// clock while out_stall is low. in_stall rises while the queue holds 3 or more
// words, so bytes flow at one per cycle as long as the output side keeps up; a
// byte that yields both an address and a status puts two words into the queue.
`default_nettype none

module dns_a_record_reply_parser_top
    import dnsar_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input bytes
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        final_byte,
    // result words
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [31:0]      address,
    output logic [1:0]       status,
    output logic [3:0]       record_count,
    output logic             end_of_run
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QFIXED,
        PH_ANAME,
        PH_AFIXED,
        PH_RDATA,
        PH_DONE,
        PH_ERROR
    } phase_t;

    // configuration registers
    logic [15:0] expected_id_reg;
    logic [3:0]  max_records_reg;
    logic        cfg_wr;
    logic [3:0]  limit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= '0;
            max_records_reg <= MAX_RECORDS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_EXPECTED_ID: expected_id_reg <= pwdata[15:0];
                REG_MAX_RECORDS: max_records_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_EXPECTED_ID: prdata = {16'd0, expected_id_reg};
            REG_MAX_RECORDS: prdata = {28'd0, max_records_reg};
            default:         prdata = '0;
        endcase
    end

    assign limit = (32'(max_records_reg) > MAX_RECORDS) ? 4'(MAX_RECORDS)
                                                        : max_records_reg;

    // parse state
    phase_t      phase_reg,            phase_next;
    logic [3:0]  header_position_reg,  header_position_next;
    logic [7:0]  id_high_byte_reg,     id_high_byte_next;
    logic [15:0] questions_left_reg,   questions_left_next;
    logic [15:0] answers_left_reg,     answers_left_next;
    logic [7:0]  label_bytes_left_reg, label_bytes_left_next;
    logic [7:0]  label_steps_reg,      label_steps_next;
    logic        pointer_pending_reg,  pointer_pending_next;
    logic [3:0]  fixed_position_reg,   fixed_position_next;
    logic [15:0] record_type_reg,      record_type_next;
    logic [15:0] rdata_left_reg,       rdata_left_next;
    logic [31:0] address_shift_reg,    address_shift_next;
    logic [3:0]  found_count_reg,      found_count_next;
    logic [1:0]  verdict_reg,          verdict_next;

    // output queue
    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg,  count_next;

    logic    accept;
    logic    pop;
    logic    emit_addr;
    logic    name_end;
    logic    name_err;
    logic [1:0] push_n;
    logic [1:0] final_status;
    result_t addr_word;
    result_t status_word;

    assign in_stall = (count_reg > FIFO_CW'(FIFO_DEPTH - 2));
    assign accept   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop      = out_valid && !out_stall;

    function automatic phase_t after_answer(input logic [15:0] ans,
                                            input logic [3:0]  fc,
                                            input logic [3:0]  lim);
        if (ans == '0 || fc >= lim)
            return PH_DONE;
        else
            return PH_ANAME;
    endfunction

    always_comb
    begin
        phase_next            = phase_reg;
        header_position_next  = header_position_reg;
        id_high_byte_next     = id_high_byte_reg;
        questions_left_next   = questions_left_reg;
        answers_left_next     = answers_left_reg;
        label_bytes_left_next = label_bytes_left_reg;
        label_steps_next      = label_steps_reg;
        pointer_pending_next  = pointer_pending_reg;
        fixed_position_next   = fixed_position_reg;
        record_type_next      = record_type_reg;
        rdata_left_next       = rdata_left_reg;
        address_shift_next    = address_shift_reg;
        found_count_next      = found_count_reg;
        verdict_next          = verdict_reg;
        emit_addr             = 1'b0;
        name_end              = 1'b0;
        name_err              = 1'b0;
        final_status          = STATUS_MALFORMED;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    case (header_position_reg)
                        4'd0: id_high_byte_next = rx_byte;
                        4'd1:
                        begin
                            if ({id_high_byte_reg, rx_byte} != expected_id_reg)
                                phase_next = PH_ERROR;
                        end
                        4'd2:
                        begin
                            if (!rx_byte[7])
                                phase_next = PH_ERROR;
                        end
                        4'd3:
                        begin
                            if (rx_byte[3:0] != 4'd0)
                                verdict_next = VERDICT_EMPTY;
                        end
                        4'd4, 4'd5:
                            questions_left_next = {questions_left_reg[7:0], rx_byte};
                        4'd6, 4'd7:
                            answers_left_next = {answers_left_reg[7:0], rx_byte};
                        default: ;
                    endcase
                    if (phase_next == PH_HEADER)
                    begin
                        if (header_position_reg >= HEADER_LAST)
                        begin
                            if (verdict_next == VERDICT_EMPTY)
                                phase_next = PH_DONE;
                            else if (questions_left_next != '0)
                                phase_next = PH_QNAME;
                            else
                                phase_next = after_answer(answers_left_next,
                                                          found_count_reg, limit);
                        end
                        else
                        begin
                            header_position_next = header_position_reg + 4'd1;
                        end
                    end
                end
                PH_QNAME, PH_ANAME:
                begin
                    if (pointer_pending_reg)
                    begin
                        pointer_pending_next = 1'b0;
                        name_end = 1'b1;
                    end
                    else if (label_bytes_left_reg != '0)
                        label_bytes_left_next = label_bytes_left_reg - 8'd1;
                    else if (rx_byte == 8'd0)
                        name_end = 1'b1;
                    else if (rx_byte[7:6] == 2'b11)
                        pointer_pending_next = 1'b1;
                    else
                    begin
                        label_bytes_left_next = rx_byte;
                        label_steps_next = label_steps_reg + 8'd1;
                        name_err = (label_steps_reg >= MAX_LABELS);
                    end
                    if (name_err)
                        phase_next = PH_ERROR;
                    else if (name_end)
                    begin
                        fixed_position_next = '0;
                        phase_next = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                    end
                end
                PH_QFIXED:
                begin
                    fixed_position_next = fixed_position_reg + 4'd1;
                    if (fixed_position_next >= QFIXED_LEN)
                    begin
                        questions_left_next = questions_left_reg - 16'd1;
                        if (questions_left_next != '0)
                            phase_next = PH_QNAME;
                        else
                            phase_next = after_answer(answers_left_reg,
                                                      found_count_reg, limit);
                    end
                end
                PH_AFIXED:
                begin
                    if (fixed_position_reg < 4'd2)
                        record_type_next = {record_type_reg[7:0], rx_byte};
                    else if (fixed_position_reg >= AFIXED_RDLEN)
                        rdata_left_next = {rdata_left_reg[7:0], rx_byte};
                    fixed_position_next = fixed_position_reg + 4'd1;
                    if (fixed_position_next >= AFIXED_LEN)
                    begin
                        if (record_type_next != TYPE_A || rdata_left_next != A_RDATA_LEN)
                            record_type_next = '0;
                        address_shift_next = '0;
                        if (rdata_left_next == '0)
                        begin
                            answers_left_next = answers_left_reg - 16'd1;
                            phase_next = after_answer(answers_left_next,
                                                      found_count_reg, limit);
                        end
                        else
                            phase_next = PH_RDATA;
                    end
                end
                PH_RDATA:
                begin
                    address_shift_next = {address_shift_reg[23:0], rx_byte};
                    rdata_left_next = rdata_left_reg - 16'd1;
                    if (rdata_left_next == '0)
                    begin
                        if (record_type_reg == TYPE_A)
                        begin
                            found_count_next = found_count_reg + 4'd1;
                            emit_addr = 1'b1;
                        end
                        answers_left_next = answers_left_reg - 16'd1;
                        phase_next = after_answer(answers_left_next,
                                                  found_count_next, limit);
                    end
                end
                default: ;
            endcase

            // a fresh name starts with clean label tracking
            if ((phase_next == PH_QNAME || phase_next == PH_ANAME) &&
                phase_next != phase_reg)
            begin
                label_bytes_left_next = '0;
                label_steps_next      = '0;
                pointer_pending_next  = 1'b0;
            end
        end

        if (phase_next != PH_DONE)
            final_status = STATUS_MALFORMED;
        else if (verdict_next == VERDICT_EMPTY)
            final_status = STATUS_EMPTY;
        else if (found_count_next != '0)
            final_status = STATUS_FOUND;
        else
            final_status = STATUS_EMPTY;

        addr_word.kind         = KIND_ADDRESS;
        addr_word.address      = address_shift_next;
        addr_word.status       = STATUS_FOUND;
        addr_word.record_count = found_count_next;
        addr_word.end_of_run   = !final_byte;

        status_word.kind         = KIND_STATUS;
        status_word.address      = '0;
        status_word.status       = final_status;
        status_word.record_count = found_count_next;
        status_word.end_of_run   = 1'b1;

        // message end returns the parser to its starting point
        if (accept && final_byte)
        begin
            phase_next            = PH_HEADER;
            header_position_next  = '0;
            id_high_byte_next     = '0;
            questions_left_next   = '0;
            answers_left_next     = '0;
            label_bytes_left_next = '0;
            label_steps_next      = '0;
            pointer_pending_next  = 1'b0;
            fixed_position_next   = '0;
            record_type_next      = '0;
            rdata_left_next       = '0;
            address_shift_next    = '0;
            found_count_next      = '0;
            verdict_next          = VERDICT_NONE;
        end
    end

    always_comb
    begin
        push_n      = {1'b0, emit_addr} + {1'b0, accept && final_byte};
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HEADER;
            header_position_reg  <= '0;
            id_high_byte_reg     <= '0;
            questions_left_reg   <= '0;
            answers_left_reg     <= '0;
            label_bytes_left_reg <= '0;
            label_steps_reg      <= '0;
            pointer_pending_reg  <= 1'b0;
            fixed_position_reg   <= '0;
            record_type_reg      <= '0;
            rdata_left_reg       <= '0;
            address_shift_reg    <= '0;
            found_count_reg      <= '0;
            verdict_reg          <= VERDICT_NONE;
            wr_ptr_reg           <= '0;
            rd_ptr_reg           <= '0;
            count_reg            <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            header_position_reg  <= header_position_next;
            id_high_byte_reg     <= id_high_byte_next;
            questions_left_reg   <= questions_left_next;
            answers_left_reg     <= answers_left_next;
            label_bytes_left_reg <= label_bytes_left_next;
            label_steps_reg      <= label_steps_next;
            pointer_pending_reg  <= pointer_pending_next;
            fixed_position_reg   <= fixed_position_next;
            record_type_reg      <= record_type_next;
            rdata_left_reg       <= rdata_left_next;
            address_shift_reg    <= address_shift_next;
            found_count_reg      <= found_count_next;
            verdict_reg          <= verdict_next;
            wr_ptr_reg           <= wr_ptr_next;
            rd_ptr_reg           <= rd_ptr_next;
            count_reg            <= count_next;
        end
    end

    // queue payload, an address word goes ahead of the status word
    always_ff @(posedge clk)
    begin
        if (emit_addr)
        begin
            fifo_mem[wr_ptr_reg] <= addr_word;
            if (accept && final_byte)
                fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= status_word;
        end
        else if (accept && final_byte)
            fifo_mem[wr_ptr_reg] <= status_word;
    end

    assign kind         = fifo_mem[rd_ptr_reg].kind;
    assign address      = fifo_mem[rd_ptr_reg].address;
    assign status       = fifo_mem[rd_ptr_reg].status;
    assign record_count = fifo_mem[rd_ptr_reg].record_count;
    assign end_of_run   = fifo_mem[rd_ptr_reg].end_of_run;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> phase_reg == PH_HEADER &&
            header_position_reg == '0 && found_count_reg == '0)
        else $error("parse state not cleared after message end");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STATUS |-> end_of_run && address == '0)
        else $error("status word malformed");

    a_addr_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ADDRESS |-> record_count != '0 &&
            status == STATUS_FOUND)
        else $error("address word without record count");
`endif

endmodule

`default_nettype wire

// ----- tb/dns_a_record_reply_parser_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dns_a_record_reply_parser_checker
// Watches the register port and both byte and result channels of the DNS
// reply parser. It tracks the parse of every accepted byte with its own model
// and compares each result word against the oldest predicted one.
// ---------------------------------------------------------------------------
module dns_a_record_reply_parser_checker
    import dnsar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        final_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        kind,
    input  wire logic [31:0] address,
    input  wire logic [1:0]  status,
    input  wire logic [3:0]  record_count,
    input  wire logic        end_of_run,
    output int               errors,
    output int               pending
);

    localparam int        SHOW_MAX = 30;
    localparam logic [1:0] PTR_TAG = 2'b11;

    typedef enum logic [2:0] {
        ST_HEADER, ST_QNAME, ST_QFIXED, ST_ANAME, ST_AFIXED, ST_RDATA, ST_DONE, ST_ERROR
    } stage_t;

    typedef enum logic [1:0] {NAME_MORE, NAME_END, NAME_BAD} name_step_t;

    // register copies
    logic [15:0] exp_id;
    logic [3:0]  max_cfg;

    // parse state
    stage_t      stage;
    logic [3:0]  hdr_idx;
    logic [7:0]  id_msb;
    logic [15:0] qd_left;
    logic [15:0] an_left;
    logic [7:0]  skip_len;
    logic [7:0]  label_cnt;
    logic        ptr_second;
    logic [3:0]  fixed_idx;
    logic [15:0] rr_type;
    logic [15:0] rd_left;
    logic [31:0] addr_acc;
    logic [3:0]  a_count;
    logic        rcode_set;

    result_t expected_words[$];

    task automatic flag_error(input string what);
        errors++;
        if (errors <= SHOW_MAX)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic clear_parse();
        stage = ST_HEADER;
        hdr_idx = '0;
        id_msb = '0;
        qd_left = '0;
        an_left = '0;
        skip_len = '0;
        label_cnt = '0;
        ptr_second = 1'b0;
        fixed_idx = '0;
        rr_type = '0;
        rd_left = '0;
        addr_acc = '0;
        a_count = '0;
        rcode_set = 1'b0;
    endtask

    function automatic logic [3:0] record_cap();
        return (max_cfg > MAX_RECORDS_DEF) ? 4'(MAX_RECORDS_DEF) : max_cfg;
    endfunction

    task automatic start_name(input stage_t next);
        stage = next;
        skip_len = '0;
        label_cnt = '0;
        ptr_second = 1'b0;
    endtask

    // decide between another answer and the end of parsing
    task automatic after_record();
        if (an_left == 0 || a_count >= record_cap())
            stage = ST_DONE;
        else
            start_name(ST_ANAME);
    endtask

    function automatic name_step_t walk_name(input logic [7:0] b);
        if (ptr_second) begin
            ptr_second = 1'b0;
            return NAME_END;
        end
        if (skip_len != 0) begin
            skip_len--;
            return NAME_MORE;
        end
        if (b == 8'h00)
            return NAME_END;
        // compression pointer ends the name after its second byte
        if (b[7:6] == PTR_TAG) begin
            ptr_second = 1'b1;
            return NAME_MORE;
        end
        skip_len = b;
        label_cnt++;
        return (label_cnt > MAX_LABELS) ? NAME_BAD : NAME_MORE;
    endfunction

    task automatic advance_parser(input logic [7:0] b, input logic fin);
        result_t    addr_w;
        result_t    stat_w;
        logic       got_addr;
        name_step_t step;
        addr_w = '0;
        stat_w = '0;
        got_addr = 1'b0;
        case (stage)
            ST_HEADER: begin
                case (hdr_idx)
                    4'd0: id_msb = b;
                    4'd1: if ({id_msb, b} != exp_id) stage = ST_ERROR;
                    4'd2: if (!b[7]) stage = ST_ERROR;
                    4'd3: if (b[3:0] != 4'h0) rcode_set = 1'b1;
                    4'd4, 4'd5: qd_left = {qd_left[7:0], b};
                    4'd6, 4'd7: an_left = {an_left[7:0], b};
                    default: ;
                endcase
                if (stage == ST_HEADER) begin
                    if (hdr_idx >= HEADER_LAST) begin
                        if (rcode_set)
                            stage = ST_DONE;
                        else if (qd_left != 0)
                            start_name(ST_QNAME);
                        else
                            after_record();
                    end else begin
                        hdr_idx++;
                    end
                end
            end
            ST_QNAME, ST_ANAME: begin
                step = walk_name(b);
                if (step == NAME_BAD) begin
                    stage = ST_ERROR;
                end else if (step == NAME_END) begin
                    fixed_idx = '0;
                    stage = (stage == ST_QNAME) ? ST_QFIXED : ST_AFIXED;
                end
            end
            ST_QFIXED: begin
                fixed_idx++;
                if (fixed_idx >= QFIXED_LEN) begin
                    qd_left--;
                    if (qd_left != 0)
                        start_name(ST_QNAME);
                    else
                        after_record();
                end
            end
            ST_AFIXED: begin
                if (fixed_idx < 4'd2)
                    rr_type = {rr_type[7:0], b};
                else if (fixed_idx >= AFIXED_RDLEN)
                    rd_left = {rd_left[7:0], b};
                fixed_idx++;
                if (fixed_idx >= AFIXED_LEN) begin
                    if (rr_type != TYPE_A || rd_left != A_RDATA_LEN)
                        rr_type = '0;
                    addr_acc = '0;
                    if (rd_left == 0) begin
                        an_left--;
                        after_record();
                    end else begin
                        stage = ST_RDATA;
                    end
                end
            end
            ST_RDATA: begin
                addr_acc = {addr_acc[23:0], b};
                rd_left--;
                if (rd_left == 0) begin
                    if (rr_type == TYPE_A) begin
                        a_count++;
                        got_addr = 1'b1;
                        addr_w.kind = KIND_ADDRESS;
                        addr_w.address = addr_acc;
                        addr_w.record_count = a_count;
                    end
                    an_left--;
                    after_record();
                end
            end
            default: ;
        endcase
        if (got_addr) begin
            addr_w.end_of_run = !fin;
            expected_words.push_back(addr_w);
        end
        if (fin) begin
            stat_w.kind = KIND_STATUS;
            if (stage != ST_DONE)
                stat_w.status = STATUS_MALFORMED;
            else if (rcode_set || a_count == 0)
                stat_w.status = STATUS_EMPTY;
            else
                stat_w.status = STATUS_FOUND;
            stat_w.record_count = a_count;
            stat_w.end_of_run = 1'b1;
            expected_words.push_back(stat_w);
            clear_parse();
        end
    endtask

    always @(posedge clk) begin
        result_t w;
        if (!rst_n) begin
            clear_parse();
            exp_id = '0;
            max_cfg = MAX_RECORDS_RST;
            expected_words.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MAX_RECORDS)
                    max_cfg = pwdata[3:0];
                else
                    exp_id = pwdata[15:0];
            end
            if (in_valid && !in_stall)
                advance_parser(rx_byte, final_byte);
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    flag_error($sformatf("unexpected word kind %0d address %h status %0d",
                                         kind, address, status));
                end else begin
                    w = expected_words.pop_front();
                    if (kind !== w.kind)
                        flag_error($sformatf("kind %0d, want %0d", kind, w.kind));
                    if (address !== w.address)
                        flag_error($sformatf("address %h, want %h", address, w.address));
                    if (status !== w.status)
                        flag_error($sformatf("status %0d, want %0d", status, w.status));
                    if (record_count !== w.record_count)
                        flag_error($sformatf("record_count %0d, want %0d",
                                             record_count, w.record_count));
                    if (end_of_run !== w.end_of_run)
                        flag_error($sformatf("end_of_run %0d, want %0d",
                                             end_of_run, w.end_of_run));
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

// ----- tb/dns_a_record_reply_parser_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dns_a_record_reply_parser_top_tb
// Feeds DNS replies byte by byte into the parser: a directed set of corner
// cases, then random well-formed, broken and noise replies under several
// register settings and idle patterns. The checker judges every result word.
// ---------------------------------------------------------------------------
module dns_a_record_reply_parser_top_tb;
    import dnsar_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 20;
    localparam int LIMIT         = 400000;
    localparam logic [15:0] TYPE_AAAA  = 16'd28;
    localparam logic [15:0] TYPE_OTHER = 16'd5;
    localparam logic [1:0]  PTR_TAG    = 2'b11;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        final_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [31:0] address;
    logic [1:0]  status;
    logic [3:0]  record_count;
    logic        end_of_run;

    int errors;
    int pending;
    int cycles = 0;
    int sent_bytes = 0;
    int src_idle_pct = 6;
    int sink_idle_pct = 87;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic [15:0] cur_id = '0;
    logic [7:0]  msg[$];

    dns_a_record_reply_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .address      (address),
        .status       (status),
        .record_count (record_count),
        .end_of_run   (end_of_run)
    );

    dns_a_record_reply_parser_checker reply_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .final_byte   (final_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .address      (address),
        .status       (status),
        .record_count (record_count),
        .end_of_run   (end_of_run),
        .errors       (errors),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when one is requested
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall = 1'b1;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall = 1'b1;
        end else begin
            out_stall = ($urandom_range(99) < sink_idle_pct);
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        paddr = {idx, 2'b00};
        pwdata = value;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        final_byte = fin;
        do @(posedge clk); while (in_stall);
        sent_bytes++;
        @(negedge clk);
    endtask

    // send the reply up to and including byte index cut, flagged final there
    task automatic send_msg(input int cut);
        for (int i = 0; i <= cut; i++)
            send_byte(msg[i], i == cut);
        msg.delete();
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put16(input logic [15:0] v);
        msg.push_back(v[15:8]);
        msg.push_back(v[7:0]);
    endtask

    task automatic put_rand(input int n);
        repeat (n) msg.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_header(input logic [15:0] id, input logic [7:0] flags_hi,
                              input logic [7:0] flags_lo, input logic [15:0] qd,
                              input logic [15:0] an);
        put16(id);
        msg.push_back(flags_hi);
        msg.push_back(flags_lo);
        put16(qd);
        put16(an);
        put_rand(4);
    endtask

    task automatic put_name(input int labels, input int max_len, input logic ptr);
        int len;
        repeat (labels) begin
            len = (max_len > 1 && $urandom_range(29) == 0) ? $urandom_range(64, 191)
                                                           : $urandom_range(1, max_len);
            msg.push_back(8'(len));
            put_rand(len);
        end
        if (ptr) begin
            msg.push_back({PTR_TAG, 6'($urandom_range(63))});
            msg.push_back(8'($urandom_range(255)));
        end else begin
            msg.push_back(8'h00);
        end
    endtask

    task automatic put_question();
        put_name($urandom_range(3), 12, 1'($urandom_range(1)));
        put_rand(4);
    endtask

    task automatic put_rr(input logic [15:0] rtype, input logic [15:0] rdlen, input int body);
        if ($urandom_range(9) < 7)
            put_name(0, 1, 1'b1);
        else
            put_name($urandom_range(1, 2), 12, 1'($urandom_range(1)));
        put16(rtype);
        put_rand(6);
        put16(rdlen);
        put_rand(body);
    endtask

    task automatic put_a(input logic [31:0] ip);
        put_rr(TYPE_A, A_RDATA_LEN, 0);
        put16(ip[31:16]);
        put16(ip[15:0]);
    endtask

    task automatic random_reply();
        int          pick;
        int          qd;
        int          n_ans;
        int          cut;
        int          sel;
        logic [15:0] id;
        logic [15:0] an_hdr;
        logic [15:0] rl;
        logic [7:0]  flags_hi;
        logic [7:0]  flags_lo;
        pick = $urandom_range(99);
        if (pick < 8) begin
            put_rand($urandom_range(1, 24));
            send_msg(msg.size() - 1);
            return;
        end
        id = cur_id;
        flags_hi = {1'b1, 7'($urandom)};
        flags_lo = {4'($urandom), 4'h0};
        if (pick < 12)
            id = cur_id ^ (16'h1 << $urandom_range(15));
        else if (pick < 16)
            flags_hi[7] = 1'b0;
        else if (pick < 22)
            flags_lo[3:0] = 4'($urandom_range(1, 15));
        qd = $urandom_range(2);
        n_ans = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(5);
        an_hdr = 16'(n_ans);
        sel = $urandom_range(19);
        if (sel == 0)
            an_hdr = 16'(n_ans + $urandom_range(1, 2));
        else if (sel == 1)
            an_hdr = 16'hFFFF;
        else if (sel == 2 && n_ans > 0)
            an_hdr = 16'(n_ans - 1);
        put_header(id, flags_hi, flags_lo, 16'(qd), an_hdr);
        repeat (qd) begin
            if ($urandom_range(49) == 0) begin
                put_name($urandom_range(126, 130), 1, 1'b0);
                put_rand(4);
            end else begin
                put_question();
            end
        end
        repeat (n_ans) begin
            sel = $urandom_range(9);
            if (sel < 7) begin
                put_a($urandom);
            end else if (sel == 7) begin
                rl = 16'($urandom_range(6));
                put_rr(16'($urandom_range(2, 65535)), rl, int'(rl));
            end else if (sel == 8) begin
                rl = 16'($urandom_range(8));
                if (rl == A_RDATA_LEN)
                    rl = A_RDATA_LEN + 16'd1;
                put_rr(TYPE_A, rl, int'(rl));
            end else begin
                put_rr(TYPE_AAAA, 16'd16, 16);
            end
        end
        put_rand($urandom_range(2));
        cut = msg.size() - 1;
        if ($urandom_range(9) == 0)
            cut = $urandom_range(msg.size() - 1);
        send_msg(cut);
    endtask

    initial begin
        logic [15:0] id_v;
        logic [3:0]  max_v;
        logic [31:0] word;
        int          start;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rx_byte = '0;
        final_byte = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // header only, nothing asked: well-formed but empty
        put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd0);
        send_msg(msg.size() - 1);
        // one question, one A answer, all flag bits set except rcode
        put_header(16'h0000, 8'hFF, 8'hF0, 16'd1, 16'd1);
        put_question();
        put_a($urandom);
        send_msg(msg.size() - 1);
        // extreme addresses, skipped types and a wrong-length A; last byte gives two words
        put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd4);
        put_a(32'hFFFF_FFFF);
        put_rr(TYPE_AAAA, 16'd16, 16);
        put_rr(TYPE_A, 16'd5, 5);
        put_a(32'h0000_0000);
        send_msg(msg.size() - 1);
        // empty rdata record, then trailing bytes after parsing is done
        put_header(16'h0000, 8'h80, 8'h00, 16'd2, 16'd2);
        put_question();
        put_question();
        put_rr(TYPE_OTHER, 16'd0, 0);
        put_a($urandom);
        put_rand(3);
        send_msg(msg.size() - 1);
        // id mismatch and response bit clear
        put_header(16'hFFFF, 8'h80, 8'h00, 16'd0, 16'd0);
        put_rand(5);
        send_msg(msg.size() - 1);
        put_header(16'h0000, 8'h7F, 8'h00, 16'd0, 16'd0);
        send_msg(msg.size() - 1);
        // nonzero rcode: at the last header byte, with a body, and cut short
        put_header(16'h0000, 8'h80, 8'h05, 16'd0, 16'd0);
        send_msg(msg.size() - 1);
        put_header(16'h0000, 8'h80, 8'h0F, 16'd1, 16'd1);
        put_rand(10);
        send_msg(msg.size() - 1);
        put_header(16'h0000, 8'h80, 8'h01, 16'd0, 16'd0);
        send_msg(10);
        // single-byte message
        msg.push_back(8'h00);
        send_msg(0);
        // cut inside a question name, question fixed bytes, an answer's name or fixed bytes, rdata
        put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd0);
        put_name(3, 5, 1'b0);
        send_msg(14);
        put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd0);
        msg.push_back(8'h00);
        put_rand(4);
        send_msg(14);
        put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd1);
        put_a($urandom);
        send_msg(17);
        put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'd1);
        put_a($urandom);
        send_msg(msg.size() - 2);
        // label count at the limit and one past it
        put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd1);
        put_name(128, 1, 1'b0);
        put_rand(4);
        put_a($urandom);
        send_msg(msg.size() - 1);
        put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd0);
        put_name(129, 1, 1'b0);
        put_rand(4);
        send_msg(msg.size() - 1);
        // longest label length and the low end of the long range, pointer end
        put_header(16'h0000, 8'h80, 8'h00, 16'd1, 16'd1);
        msg.push_back(8'hBF);
        put_rand(191);
        msg.push_back(8'h40);
        put_rand(64);
        msg.push_back({PTR_TAG, 6'h00});
        msg.push_back(8'h0C);
        put_rand(4);
        put_a($urandom);
        send_msg(msg.size() - 1);
        wait_idle();

        // result side held off while nine A records come in; the cap stops at eight
        hold_req++;
        put_header(16'h0000, 8'h80, 8'h00, 16'd0, 16'hFFFF);
        repeat (9) put_a($urandom);
        put_rand(2);
        send_msg(msg.size() - 1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin id_v = 16'hFFFF; max_v = 4'd1; end
                1: begin id_v = 16'($urandom); max_v = 4'd8; end
                2: begin id_v = 16'($urandom); max_v = 4'd0; end
                3: begin id_v = 16'h0000; max_v = 4'd15; end
                default: begin id_v = 16'($urandom); max_v = 4'($urandom_range(1, 8)); end
            endcase
            word = $urandom;
            word[15:0] = id_v;
            write_reg(REG_EXPECTED_ID, word);
            word = $urandom;
            word[3:0] = max_v;
            write_reg(REG_MAX_RECORDS, word);
            cur_id = id_v;
            if (ph < 2) begin
                src_idle_pct = 6;
                sink_idle_pct = 87;
            end else if (ph < 4) begin
                src_idle_pct = 87;
                sink_idle_pct = 6;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            start = sent_bytes;
            while (sent_bytes - start < PHASE_BYTES)
                random_reply();
            wait_idle();
        end

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dnsar_pkg.sv
hw/rtl/dns_a_record_reply_parser_top.sv
tb/dns_a_record_reply_parser_checker.sv
tb/dns_a_record_reply_parser_top_tb.sv
